/* design/frp_pkg.sv */
// ----------------------------------------------------------------------------
// frp_pkg - shared types and constants of the first-fit rectangle placer
// payload structs, stored-entry layout, cell control and status codes
// ----------------------------------------------------------------------------
package frp_pkg;

  localparam int FRP_MAX_RECTS = 64;

  // register widths
  localparam int AW_W   = 13;
  localparam int STEP_W = 9;
  localparam int CFG_W  = 13;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PLACEMENT_STEP = 1'b1;

  // register reset values and the atlas width maximum
  localparam logic [AW_W-1:0]   AW_RESET   = 13'd1024;
  localparam logic [STEP_W-1:0] STEP_RESET = 9'd1;
  localparam logic [AW_W-1:0]   AW_MAX     = 13'd4096;

  // candidate coordinate widths
  localparam int X_W = 14;
  localparam int Y_W = 17;

  // jump unit: quotient bits of (edge - x) / step, and their counter
  localparam int JUMP_BITS = 13;
  localparam int JUMP_CNT_W = 4;
  localparam int JUMP_ACC_W = 21;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_WIDE  = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NO_ROWS   = 2'd3;

  typedef struct packed {
    logic        first;
    logic [11:0] rect_width;
    logic [11:0] rect_height;
  } in_item_t;

  typedef struct packed {
    logic [11:0] pos_x;
    logic [15:0] pos_y;
    logic [1:0]  status;
    logic [15:0] atlas_height;
  } out_item_t;

  // one stored rectangle
  typedef struct packed {
    logic [11:0] x;
    logic [15:0] y;
    logic [11:0] w;
    logic [11:0] h;
  } entry_t;

  // per-cycle control broadcast along the chain
  typedef struct packed {
    logic rotate;
    logic write;
  } cell_ctl_t;

  // request to the jump unit
  typedef struct packed {
    logic           start;
    logic [X_W-1:0] x;
    logic [X_W-1:0] edge_x;
  } jump_req_t;

endpackage

/* design/frp_cell.sv */
// ----------------------------------------------------------------------------
// frp_cell - one stored rectangle of the placer's ring
// takes its neighbour's entry on rotate, or the new entry when it is the first free cell
// ----------------------------------------------------------------------------
module frp_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic               clk,
  input  frp_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]      count,
  input  frp_pkg::entry_t    wr_entry,
  input  frp_pkg::entry_t    next_entry,
  input  frp_pkg::entry_t    head_entry,
  output frp_pkg::entry_t    entry
);
  import frp_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;
  logic   is_last;
  logic   is_free;

  // last occupied cell closes the ring back to the head
  assign is_last = (count == CW'(IDX + 1));
  assign is_free = (count == CW'(IDX));

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.write && is_free) begin
      entry_nxt = wr_entry;
    end else if (ctl.rotate) begin
      entry_nxt = is_last ? head_entry : next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

/* design/frp_jump.sv */
// ----------------------------------------------------------------------------
// frp_jump - skip unit of the placer
// finds the first grid x beyond a hit box's right edge, one quotient bit a cycle
// ----------------------------------------------------------------------------
module frp_jump (
  input  logic                        clk,
  input  logic                        rst_n,
  input  frp_pkg::jump_req_t          req,
  input  logic [frp_pkg::STEP_W-1:0]  step,
  output logic                        done,
  output logic [frp_pkg::X_W-1:0]     x_new
);
  import frp_pkg::*;

  logic                  busy_r, busy_nxt;
  logic [JUMP_CNT_W-1:0] bit_r, bit_nxt;
  logic [JUMP_ACC_W-1:0] acc_r, acc_nxt;
  logic [X_W-1:0]        edge_r, edge_nxt;
  logic                  done_r, done_nxt;
  logic [JUMP_ACC_W-1:0] shifted;
  logic [JUMP_ACC_W-1:0] trial;
  logic [JUMP_ACC_W-1:0] result;

  assign shifted = JUMP_ACC_W'(step) << bit_r;
  assign trial   = acc_r + shifted;
  assign result  = acc_r + JUMP_ACC_W'(step);

  always_comb begin
    busy_nxt = busy_r;
    bit_nxt  = bit_r;
    acc_nxt  = acc_r;
    edge_nxt = edge_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      bit_nxt  = JUMP_CNT_W'(JUMP_BITS - 1);
      acc_nxt  = JUMP_ACC_W'(req.x);
      edge_nxt = req.edge_x;
    end else if (busy_r) begin
      // keep the largest x + k*step that still lies on the edge or left of it
      if (trial <= JUMP_ACC_W'(edge_r)) begin
        acc_nxt = trial;
      end
      if (bit_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        bit_nxt = bit_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    bit_r  <= bit_nxt;
    acc_r  <= acc_nxt;
    edge_r <= edge_nxt;
  end

  assign done  = done_r;
  assign x_new = result[X_W-1:0];

endmodule

/* design/first_fit_rectangle_placer.sv */
// ----------------------------------------------------------------------------
// first_fit_rectangle_placer - first-fit placement of rectangles in an atlas
// scans grid rows top down and stores each placed box in a ring of cells
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_stall    in_data  (first, width, height)
//  out_     output     out_valid / out_stall  out_data (x, y, status, height)
//  cfg_     input      cfg_wr_en              cfg_index, cfg_wr_data
//
// one transaction at a time: the input is stalled from acceptance until the
// result is loaded into the output register. a rectangle refused before the
// scan goes straight to its result; otherwise each row is started in turn
// and, unless it lies below every stored box, the stored boxes are compared
// one by one, with the skip unit called on each hit box, until the row is
// left or a lap closes; a placed box is stored before the result. the ring
// rotates one stored box past the compare point per cycle while checking,
// and the skip unit produces one quotient bit per cycle. reset (synchronous,
// active low) empties the store and loads the register defaults; the stored
// boxes themselves are never cleared. a stalled output holds its transaction
// while the next input may already be accepted.
//
module first_fit_rectangle_placer #(
  parameter int MAX_RECTS = frp_pkg::FRP_MAX_RECTS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  frp_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output frp_pkg::out_item_t           out_data,
  input  logic                         cfg_wr_en,
  input  logic [frp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [frp_pkg::CFG_W-1:0]    cfg_wr_data
);
  import frp_pkg::*;

  localparam int CW = $clog2(MAX_RECTS + 1);

  // controller states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVAL   = 3'd1;
  localparam logic [2:0] S_ROW    = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_JUMP   = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  // configuration
  logic [AW_W-1:0]   aw_r;
  logic [STEP_W-1:0] step_r;
  logic [AW_W-1:0]   aw_eff;
  logic [STEP_W-1:0] step_eff;

  // control and candidate state
  logic [2:0]      state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   chk_r, chk_nxt;
  logic [15:0]     maxb_r, maxb_nxt;
  logic [11:0]     w_r, w_nxt;
  logic [11:0]     h_r, h_nxt;
  logic [AW_W-1:0] limit_r, limit_nxt;
  logic [X_W-1:0]  x_r, x_nxt;
  logic [Y_W-1:0]  y_r, y_nxt;
  logic [1:0]      stat_r, stat_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;

  // ring of stored boxes
  entry_t    cells [MAX_RECTS];
  entry_t    head;
  entry_t    new_entry;
  cell_ctl_t ctl;

  // skip unit
  jump_req_t      jreq;
  logic           jdone;
  logic [X_W-1:0] jx;

  logic           in_take;
  logic           hit;
  logic [12:0]    head_right;
  logic [X_W:0]   cand_right;
  logic [Y_W-1:0] head_bottom;
  logic [Y_W-1:0] cand_bottom;
  logic           out_free;

  // atlas widths above the maximum act as the maximum, a zero step as one
  assign aw_eff   = (aw_r > AW_MAX) ? AW_MAX : aw_r;
  assign step_eff = (step_r == '0) ? STEP_W'(1) : step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r   <= AW_RESET;
      step_r <= STEP_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ATLAS_WIDTH:    aw_r   <= cfg_wr_data;
        REG_PLACEMENT_STEP: step_r <= cfg_wr_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // the chain: cell i takes cell i+1, the last occupied cell takes the head
  assign head = cells[0];

  genvar gi;
  generate
    for (gi = 0; gi < MAX_RECTS; gi++) begin : g_cell
      entry_t nb;
      if (gi == MAX_RECTS - 1) begin : g_end
        assign nb = cells[0];
      end else begin : g_mid
        assign nb = cells[gi + 1];
      end
      frp_cell #(
        .IDX (gi),
        .CW  (CW)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .count      (count_r),
        .wr_entry   (new_entry),
        .next_entry (nb),
        .head_entry (cells[0]),
        .entry      (cells[gi])
      );
    end
  endgenerate

  assign new_entry = '{x: x_r[11:0], y: y_r[15:0], w: w_r, h: h_r};

  // closed-box contact between the candidate and the box at the head
  assign head_right  = {1'b0, head.x} + {1'b0, head.w};
  assign cand_right  = {1'b0, x_r} + (X_W + 1)'(w_r);
  assign head_bottom = Y_W'(head.y) + Y_W'(head.h);
  assign cand_bottom = y_r + Y_W'(h_r);
  assign hit = !((X_W'(head_right) < x_r) ||
                 ((X_W + 1)'(head.x) > cand_right) ||
                 (head_bottom < y_r) ||
                 (Y_W'(head.y) > cand_bottom));

  frp_jump u_jump (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (jreq),
    .step  (step_eff),
    .done  (jdone),
    .x_new (jx)
  );

  assign in_take  = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    chk_nxt       = chk_r;
    maxb_nxt      = maxb_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    limit_nxt     = limit_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    ctl           = '{rotate: 1'b0, write: 1'b0};
    jreq          = '{start: 1'b0, x: x_r, edge_x: X_W'(head_right)};

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          w_nxt = in_data.rect_width;
          h_nxt = in_data.rect_height;
          if (in_data.first) begin
            count_nxt = '0;
            maxb_nxt  = '0;
          end
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        // error priority: too wide, then store full
        x_nxt = '0;
        y_nxt = '0;
        if (AW_W'(w_r) >= aw_eff) begin
          stat_nxt  = ST_TOO_WIDE;
          state_nxt = S_FINISH;
        end else if (count_r == CW'(MAX_RECTS)) begin
          stat_nxt  = ST_FULL;
          state_nxt = S_FINISH;
        end else begin
          limit_nxt = aw_eff - AW_W'(w_r);
          state_nxt = S_ROW;
        end
      end
      S_ROW: begin
        x_nxt   = '0;
        chk_nxt = '0;
        if (cand_bottom > Y_W'(16'hFFFF)) begin
          stat_nxt  = ST_NO_ROWS;
          state_nxt = S_FINISH;
        end else if (y_r > Y_W'(maxb_r)) begin
          // row lies wholly below every stored box
          state_nxt = S_COMMIT;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (x_r >= X_W'(limit_r)) begin
          y_nxt     = y_r + Y_W'(step_eff);
          state_nxt = S_ROW;
        end else if (chk_r == count_r) begin
          // a full lap of the ring without contact
          state_nxt = S_COMMIT;
        end else begin
          ctl.rotate = 1'b1;
          if (hit) begin
            jreq.start = 1'b1;
            state_nxt  = S_JUMP;
          end else begin
            chk_nxt = chk_r + 1'b1;
          end
        end
      end
      S_JUMP: begin
        if (jdone) begin
          x_nxt     = jx;
          chk_nxt   = '0;
          state_nxt = S_CHECK;
        end
      end
      S_COMMIT: begin
        ctl.write = 1'b1;
        count_nxt = count_r + 1'b1;
        if (cand_bottom > Y_W'(maxb_r)) begin
          maxb_nxt = cand_bottom[15:0];
        end
        stat_nxt  = ST_OK;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt.status       = stat_r;
          out_nxt.atlas_height = maxb_r;
          if (stat_r == ST_OK) begin
            out_nxt.pos_x = x_r[11:0];
            out_nxt.pos_y = y_r[15:0];
          end else begin
            out_nxt.pos_x = '0;
            out_nxt.pos_y = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      maxb_r      <= '0;
      chk_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      maxb_r      <= maxb_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
    end
    w_r     <= w_nxt;
    h_r     <= h_nxt;
    limit_r <= limit_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    stat_r  <= stat_nxt;
    out_r   <= out_nxt;
  end

  // nothing is taken while in reset or while a transaction is in flight
  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
